// ===== rtl/rcsam_pkg.sv =====
// Package for the RC stick arming and setpoint mapper.
// Holds widths, fixed constants, the register file layout and shared structs.
// No dependencies.
package rcsam_pkg;

    // Fixed stick and throttle constants
    localparam int STICK_HALF_RANGE = 500;
    localparam int STICK_CENTER     = 1500;
    localparam int THROTTLE_MIN     = 1000;
    localparam int THROTTLE_MAX     = 2000;
    localparam int LOST_FRAMES      = 4;

    // Field widths
    localparam int PULSE_W  = 12;
    localparam int TIME_W   = 32;
    localparam int SET_W    = 16;
    localparam int FULL_W   = 15;
    localparam int STREAK_W = 3;
    localparam int SPAN_W   = $clog2(STICK_HALF_RANGE + 1);
    localparam int PROD_W   = SPAN_W + FULL_W;
    localparam int MAG_W    = PULSE_W;

    localparam logic [STREAK_W-1:0] STREAK_MAX = '1;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEAD_BAND        = 3'd0,
        CFG_ARM_THROTTLE_MAX = 3'd1,
        CFG_YAW_LOW          = 3'd2,
        CFG_YAW_HIGH         = 3'd3,
        CFG_HOLD_TIME        = 3'd4,
        CFG_SETTLE_TIME      = 3'd5,
        CFG_MAX_TILT         = 3'd6,
        CFG_MAX_YAW_RATE     = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]  dead_band;
        logic [11:0] arm_throttle_max;
        logic [11:0] yaw_low;
        logic [11:0] yaw_high;
        logic [15:0] hold_time;
        logic [15:0] settle_time;
        logic [6:0]  max_tilt;
        logic [10:0] max_yaw_rate;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        dead_band:        8'd10,
        arm_throttle_max: 12'd1100,
        yaw_low:          12'd1100,
        yaw_high:         12'd1900,
        hold_time:        16'd1000,
        settle_time:      16'd500,
        max_tilt:         7'd30,
        max_yaw_rate:     11'd200
    };

    // Arming unit status toward the merge stage
    typedef struct packed {
        logic armed;
        logic arm_edge;
        logic disarm_edge;
        logic settling;
    } t_arm_status;

endpackage

// ===== rtl/rc_stick_arming_setpoint_mapper.sv =====
// Top level of the RC stick arming and setpoint mapper.
// Instantiates rcsam_arm and three rcsam_lane copies; depends on rcsam_pkg.
//
// Channel   Dir  Handshake                 Payload
// s (frame) in   i_s_tvalid / o_s_tready   i_s_tdata: roll, pitch, throttle, yaw, now
//                                          i_s_tuser: link_lost
// m (setpt) out  o_m_tvalid / i_m_tready   o_m_tdata: roll, pitch, yaw rate, throttle
//                                          o_m_tuser: armed_now, arm_edge, disarm_edge
// cfg       in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One frame at a time: a new frame is accepted only once the last result has
// gone into the output register. Each stick lane divides bit-serially (one
// quotient bit per cycle, SPAN_W + FULL_W bits). Reset is synchronous and
// active low; it loads the register defaults and disarms. A stalled result
// waits in the output register; the lanes hold their values until it drains.
module rc_stick_arming_setpoint_mapper
    import rcsam_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Frame in
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [79:0]           i_s_tdata,   // roll[11:0], pitch[23:12], throttle[35:24],
                                               // yaw[47:36], now[79:48]
    input  logic                  i_s_tuser,   // link_lost[0]
    // Setpoints out
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [63:0]           o_m_tdata,   // roll_angle[15:0], pitch_angle[31:16],
                                               // yaw_rate[47:32], throttle_out[59:48], zero
    output logic [2:0]            o_m_tuser,   // armed_now[0], arm_edge[1], disarm_edge[2]
    // Configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_PARK
    } t_top_state;

    t_top_state          r_state;
    t_cfg                r_cfg;
    logic [PULSE_W-1:0]  r_thr;
    logic                r_m_valid;
    logic [63:0]         r_m_tdata;
    logic [2:0]          r_m_tuser;

    logic                w_accept;
    logic                w_out_free;
    logic                w_all_done;
    logic                w_load;
    logic [PULSE_W-1:0]  w_roll;
    logic [PULSE_W-1:0]  w_pitch;
    logic [PULSE_W-1:0]  w_thr_in;
    logic [PULSE_W-1:0]  w_yaw;
    logic [TIME_W-1:0]   w_now;
    logic [PULSE_W-1:0]  n_thr;
    logic [FULL_W-1:0]   w_tilt_full;
    logic [FULL_W-1:0]   w_rate_full;
    logic [2:0]          w_done;
    logic signed [SET_W-1:0] w_roll_sp;
    logic signed [SET_W-1:0] w_pitch_sp;
    logic signed [SET_W-1:0] w_yaw_sp;
    logic [SET_W-1:0]    w_roll_out;
    logic [SET_W-1:0]    w_pitch_out;
    logic [SET_W-1:0]    w_yaw_out;
    t_arm_status         w_status;

    // Unpack the frame
    assign w_roll   = i_s_tdata[11:0];
    assign w_pitch  = i_s_tdata[23:12];
    assign w_thr_in = i_s_tdata[35:24];
    assign w_yaw    = i_s_tdata[47:36];
    assign w_now    = i_s_tdata[79:48];

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    // Full-scale setpoints: degrees to 1/256 degree, deg/s to 1/16 deg/s
    assign w_tilt_full = FULL_W'({r_cfg.max_tilt, 8'd0});
    assign w_rate_full = FULL_W'({r_cfg.max_yaw_rate, 4'd0});

    // Throttle clamp; the low limit is tested first
    always_comb begin
        if (w_thr_in < PULSE_W'(THROTTLE_MIN)) begin
            n_thr = PULSE_W'(THROTTLE_MIN);
        end else if (w_thr_in > PULSE_W'(THROTTLE_MAX)) begin
            n_thr = PULSE_W'(THROTTLE_MAX);
        end else begin
            n_thr = w_thr_in;
        end
    end

    // Configuration register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DEAD_BAND:        r_cfg.dead_band        <= i_cfg_data[7:0];
                CFG_ARM_THROTTLE_MAX: r_cfg.arm_throttle_max <= i_cfg_data[11:0];
                CFG_YAW_LOW:          r_cfg.yaw_low          <= i_cfg_data[11:0];
                CFG_YAW_HIGH:         r_cfg.yaw_high         <= i_cfg_data[11:0];
                CFG_HOLD_TIME:        r_cfg.hold_time        <= i_cfg_data;
                CFG_SETTLE_TIME:      r_cfg.settle_time      <= i_cfg_data;
                CFG_MAX_TILT:         r_cfg.max_tilt         <= i_cfg_data[6:0];
                CFG_MAX_YAW_RATE:     r_cfg.max_yaw_rate     <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // Arming, debounce and settle window
    rcsam_arm u_arm (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (w_accept),
        .i_cfg            (r_cfg),
        .i_throttle_pulse (w_thr_in),
        .i_yaw_pulse      (w_yaw),
        .i_link_lost      (i_s_tuser),
        .i_now            (w_now),
        .o_status         (w_status)
    );

    // Three stick lanes run side by side on the same schedule
    rcsam_lane u_lane_roll (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_accept),
        .i_pulse     (w_roll),
        .i_full      (w_tilt_full),
        .i_dead_band (r_cfg.dead_band),
        .o_done      (w_done[0]),
        .o_value     (w_roll_sp)
    );

    rcsam_lane u_lane_pitch (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_accept),
        .i_pulse     (w_pitch),
        .i_full      (w_tilt_full),
        .i_dead_band (r_cfg.dead_band),
        .o_done      (w_done[1]),
        .o_value     (w_pitch_sp)
    );

    rcsam_lane u_lane_yaw (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_accept),
        .i_pulse     (w_yaw),
        .i_full      (w_rate_full),
        .i_dead_band (r_cfg.dead_band),
        .o_done      (w_done[2]),
        .o_value     (w_yaw_sp)
    );

    // Merge: zero the attitude setpoints while the settle window is open
    assign w_roll_out  = w_status.settling ? '0 : w_roll_sp;
    assign w_pitch_out = w_status.settling ? '0 : w_pitch_sp;
    assign w_yaw_out   = w_status.settling ? '0 : w_yaw_sp;

    assign w_all_done = &w_done;
    assign w_out_free = !r_m_valid || i_m_tready;
    assign w_load     = ((r_state == S_RUN) && w_all_done && w_out_free)
                     || ((r_state == S_PARK) && w_out_free);

    // Sequencer and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (w_all_done) begin
                        r_state <= w_out_free ? S_IDLE : S_PARK;
                    end
                end
                S_PARK: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (w_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_thr <= n_thr;
        end
        if (w_load) begin
            r_m_tdata <= {4'd0, r_thr, w_yaw_out, w_pitch_out, w_roll_out};
            r_m_tuser <= {w_status.disarm_edge, w_status.arm_edge, w_status.armed};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

endmodule

// ===== rtl/rcsam_lane.sv =====
// One stick lane: deadband, scale by a full-scale value and divide by the span.
// Uses a bit-serial restoring divider. Depends on rcsam_pkg.
module rcsam_lane
    import rcsam_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [PULSE_W-1:0]      i_pulse,
    input  logic [FULL_W-1:0]       i_full,
    input  logic [7:0]              i_dead_band,
    output logic                    o_done,
    output logic signed [SET_W-1:0] o_value
);

    localparam int CNT_W = $clog2(PROD_W);
    localparam int SPS_W = MAG_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_DIV,
        S_FIN
    } t_lane_state;

    t_lane_state            r_state;
    logic                   r_done;
    logic signed [SET_W-1:0] r_value;
    logic [MAG_W-1:0]       r_mag;
    logic                   r_neg;
    logic [FULL_W-1:0]      r_full;
    logic [7:0]             r_db;
    logic [SPAN_W-1:0]      r_span;
    logic [SPAN_W-1:0]      r_excess;
    logic                   r_zero;
    logic                   r_sat;
    logic [PROD_W-1:0]      r_quo;
    logic [SPAN_W-1:0]      r_rem;
    logic [CNT_W-1:0]       r_cnt;

    logic signed [SPS_W-1:0] w_delta;
    logic [MAG_W-1:0]        w_mag;
    logic [SPS_W-1:0]        w_excess;
    logic signed [SPS_W-1:0] w_span;
    logic                    w_zero;
    logic                    w_sat;
    logic [PROD_W-1:0]       w_prod;
    logic [SPAN_W:0]         w_trial;
    logic [SPAN_W:0]         w_diff;
    logic                    w_ge;
    logic [FULL_W-1:0]       w_abs;

    always_comb begin
        w_delta  = $signed({1'b0, i_pulse}) - $signed(SPS_W'(STICK_CENTER));
        w_mag    = w_delta[SPS_W-1] ? MAG_W'(-w_delta) : w_delta[MAG_W-1:0];
        w_excess = {1'b0, r_mag} - SPS_W'(r_db);
        w_span   = $signed(SPS_W'(STICK_HALF_RANGE)) - $signed(SPS_W'(r_db));
        w_zero   = r_mag <= MAG_W'(r_db);
        w_sat    = (w_span <= 0) || (w_excess >= SPS_W'(w_span));
        w_prod   = PROD_W'(r_excess) * PROD_W'(r_full);
        w_trial  = {r_rem, r_quo[PROD_W-1]};
        w_ge     = w_trial >= {1'b0, r_span};
        w_diff   = w_trial - {1'b0, r_span};
        if (r_zero) begin
            w_abs = '0;
        end else if (r_sat) begin
            w_abs = r_full;
        end else begin
            w_abs = r_quo[FULL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == S_FIN);
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP:  r_state <= S_MUL;
                S_MUL:   r_state <= S_DIV;
                S_DIV: begin
                    if (r_cnt == CNT_W'(PROD_W - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_mag  <= w_mag;
                r_neg  <= w_delta[SPS_W-1];
                r_full <= i_full;
                r_db   <= i_dead_band;
            end
            S_PREP: begin
                r_zero   <= w_zero;
                r_sat    <= w_sat;
                r_span   <= w_span[SPAN_W-1:0];
                r_excess <= w_excess[SPAN_W-1:0];
            end
            S_MUL: begin
                r_quo <= w_prod;
                r_rem <= '0;
                r_cnt <= '0;
            end
            S_DIV: begin
                r_rem <= w_ge ? w_diff[SPAN_W-1:0] : w_trial[SPAN_W-1:0];
                r_quo <= {r_quo[PROD_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            S_FIN: begin
                r_value <= r_neg ? -$signed({1'b0, w_abs}) : $signed({1'b0, w_abs});
            end
            default: ;
        endcase
    end

    assign o_done  = r_done;
    assign o_value = r_value;

endmodule

// ===== rtl/rcsam_arm.sv =====
// Arming unit: link-loss debounce, stick gesture timer and settle window.
// Updates its state once per frame. Depends on rcsam_pkg.
module rcsam_arm
    import rcsam_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  t_cfg               i_cfg,
    input  logic [PULSE_W-1:0] i_throttle_pulse,
    input  logic [PULSE_W-1:0] i_yaw_pulse,
    input  logic               i_link_lost,
    input  logic [TIME_W-1:0]  i_now,
    output t_arm_status        o_status
);

    logic                r_armed;
    logic [TIME_W-1:0]   r_gesture_start;
    logic [STREAK_W-1:0] r_streak;
    logic [TIME_W-1:0]   r_settle_end;
    t_arm_status         r_status;

    logic [STREAK_W-1:0] n_streak;
    logic                n_armed;
    logic [TIME_W-1:0]   n_gesture_start;
    logic [TIME_W-1:0]   n_settle_end;
    logic                w_thr_low;
    logic                w_gesture;
    logic [TIME_W-1:0]   w_elapsed;
    logic [TIME_W:0]     w_sum;
    logic                w_arm_edge;
    logic                w_settle_new;
    logic                w_settle_old;

    always_comb begin
        if (i_link_lost) begin
            n_streak = (r_streak < STREAK_MAX) ? r_streak + 1'b1 : r_streak;
        end else begin
            n_streak = '0;
        end
        w_thr_low = i_throttle_pulse <= i_cfg.arm_throttle_max;
        w_gesture = r_armed ? (w_thr_low && (i_yaw_pulse <= i_cfg.yaw_low))
                            : (w_thr_low && (i_yaw_pulse >= i_cfg.yaw_high));
        w_elapsed = i_now - r_gesture_start;

        n_armed         = r_armed;
        n_gesture_start = r_gesture_start;
        if (n_streak >= STREAK_W'(LOST_FRAMES)) begin
            n_armed         = 1'b0;
            n_gesture_start = '0;
        end else if (!w_gesture) begin
            n_gesture_start = '0;
        end else if (r_gesture_start == '0) begin
            n_gesture_start = i_now;
        end else if (w_elapsed >= TIME_W'(i_cfg.hold_time)) begin
            n_armed         = !r_armed;
            n_gesture_start = '0;
        end

        // Window end wraps modulo 2^32; compare both candidates in parallel
        w_arm_edge   = !r_armed && n_armed;
        w_sum        = {1'b0, i_now} + (TIME_W + 1)'(i_cfg.settle_time);
        w_settle_new = i_now < w_sum[TIME_W-1:0];
        w_settle_old = i_now < r_settle_end;
        n_settle_end = w_arm_edge ? w_sum[TIME_W-1:0] : r_settle_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed         <= 1'b0;
            r_gesture_start <= '0;
            r_streak        <= '0;
            r_settle_end    <= '0;
        end else if (i_start) begin
            r_armed         <= n_armed;
            r_gesture_start <= n_gesture_start;
            r_streak        <= n_streak;
            r_settle_end    <= n_settle_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_status.armed       <= n_armed;
            r_status.arm_edge    <= w_arm_edge;
            r_status.disarm_edge <= r_armed && !n_armed;
            r_status.settling    <= w_arm_edge ? w_settle_new : w_settle_old;
        end
    end

    assign o_status = r_status;

endmodule

// ===== rtl/rcsam_chk.sv =====
// Port-level checker for the RC stick arming and setpoint mapper.
// Bound to the top level below; depends on rcsam_pkg.
module rcsam_chk
    import rcsam_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata,
    input logic [2:0]  o_m_tuser
);

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("stalled result changed");

    // One frame in flight: no accept in the cycle after an accept
    a_one_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second frame taken while busy");

    // Edges agree with the armed state
    a_edges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[1] && !o_m_tuser[0])
                       && !(o_m_tuser[2] && o_m_tuser[0]))
        else $error("arm or disarm edge disagrees with armed flag");

endmodule

bind rc_stick_arming_setpoint_mapper rcsam_chk u_rcsam_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// ===== tb/rc_stick_arming_setpoint_mapper_test.sv =====
// Self-checking testbench for rc_stick_arming_setpoint_mapper: a frame stream with
// random gaps and stalls, checked against a cycle-free model of arming and stick scaling.
// Depends on rcsam_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module rc_stick_arming_setpoint_mapper_test;
    import rcsam_pkg::*;

    localparam int CLK_HALF_NS     = 4;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 40;
    localparam longint TIMEOUT_NS  = 64'd20_000_000;

    // One receiver frame and the setpoints it should produce
    typedef struct packed {
        logic [11:0] roll;
        logic [11:0] pitch;
        logic [11:0] thr;
        logic [11:0] yaw;
        logic        lost;
        logic [31:0] now;
    } t_frame;

    typedef struct packed {
        logic [15:0] roll;
        logic [15:0] pitch;
        logic [15:0] yaw;
        logic [11:0] thr;
        logic        armed;
        logic        arm_edge;
        logic        disarm_edge;
    } t_setpoint;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [79:0]           i_s_tdata;   // roll[11:0], pitch[23:12], throttle[35:24],
                                        // yaw[47:36], now[79:48]
    logic                  i_s_tuser;   // link_lost[0]
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [63:0]           o_m_tdata;   // roll_angle[15:0], pitch_angle[31:16],
                                        // yaw_rate[47:32], throttle_out[59:48], zero
    logic [2:0]            o_m_tuser;   // armed_now[0], arm_edge[1], disarm_edge[2]
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rc_stick_arming_setpoint_mapper uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #(CLK_HALF_NS);
        i_clk = 1'b0;
        #(CLK_HALF_NS);
    end

    // ------------------------------------------------------------------
    // Mapper model: register copy, arming state and pending setpoints
    // ------------------------------------------------------------------
    t_cfg        mapper_cfg;
    logic        craft_armed;
    logic [31:0] gesture_t0;      // zero means no gesture is being timed
    logic [2:0]  loss_run;
    logic [31:0] settle_deadline;
    logic [31:0] flight_ms;       // running clock for well-formed sequences

    t_setpoint   setpoint_q[$];
    int          error_count = 0;
    bit          idle_on = 1'b1;  // random gaps on both sides when set
    bit          hold_out = 1'b0; // request one long receiver hold-off

    // Deadband, then linear scale up to full deflection, truncated toward zero
    function automatic int stick_setpoint(logic [11:0] pulse, int full);
        int delta, mag, db, span, excess, v;
        delta = int'(pulse) - STICK_CENTER;
        mag   = (delta < 0) ? -delta : delta;
        db    = int'(mapper_cfg.dead_band);
        span  = STICK_HALF_RANGE - db;
        if (mag <= db)
            return 0;
        excess = mag - db;
        if (span <= 0 || excess >= span)
            v = full;
        else
            v = (excess * full) / span;
        return (delta < 0) ? -v : v;
    endfunction

    // Advance the arming state by one frame and return its setpoints
    function automatic t_setpoint predict_setpoint(t_frame f);
        t_setpoint sp;
        logic      prev_armed;
        logic      gesture;
        logic      settling;
        int        tilt_full, rate_full;
        prev_armed = craft_armed;

        if (f.lost) begin
            if (loss_run != STREAK_MAX)
                loss_run = loss_run + 3'd1;
        end else begin
            loss_run = '0;
        end

        if (loss_run >= LOST_FRAMES) begin
            craft_armed = 1'b0;
            gesture_t0  = '0;
        end else begin
            gesture = (f.thr <= mapper_cfg.arm_throttle_max) &&
                      (craft_armed ? (f.yaw <= mapper_cfg.yaw_low)
                                   : (f.yaw >= mapper_cfg.yaw_high));
            if (!gesture) begin
                gesture_t0 = '0;
            end else if (gesture_t0 == 32'd0) begin
                gesture_t0 = f.now;
            end else if (32'(f.now - gesture_t0) >= {16'd0, mapper_cfg.hold_time}) begin
                craft_armed = !craft_armed;
                gesture_t0  = '0;
            end
        end

        // Window end wraps mod 2^32, so a late arm ends settling at once
        if (!prev_armed && craft_armed)
            settle_deadline = f.now + {16'd0, mapper_cfg.settle_time};
        settling = f.now < settle_deadline;

        tilt_full = int'(mapper_cfg.max_tilt) * 256;
        rate_full = int'(mapper_cfg.max_yaw_rate) * 16;
        if (settling) begin
            sp.roll  = '0;
            sp.pitch = '0;
            sp.yaw   = '0;
        end else begin
            sp.roll  = 16'(stick_setpoint(f.roll, tilt_full));
            sp.pitch = 16'(stick_setpoint(f.pitch, tilt_full));
            sp.yaw   = 16'(stick_setpoint(f.yaw, rate_full));
        end

        if (f.thr < THROTTLE_MIN)
            sp.thr = 12'(THROTTLE_MIN);
        else if (f.thr > THROTTLE_MAX)
            sp.thr = 12'(THROTTLE_MAX);
        else
            sp.thr = f.thr;

        sp.armed       = craft_armed;
        sp.arm_edge    = !prev_armed && craft_armed;
        sp.disarm_edge = prev_armed && !craft_armed;
        return sp;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_frame make_frame(int roll, int pitch, int thr, int yaw,
                                          bit lost, logic [31:0] now);
        t_frame f;
        f.roll  = 12'(roll);
        f.pitch = 12'(pitch);
        f.thr   = 12'(thr);
        f.yaw   = 12'(yaw);
        f.lost  = lost;
        f.now   = now;
        return f;
    endfunction

    // Mostly inside the normal stick range, sometimes on the deadband edge or anywhere
    function automatic logic [11:0] stick_pulse();
        int off;
        case ($urandom_range(0, 7))
            0: return 12'($urandom_range(0, 4095));
            1: begin
                off = int'(mapper_cfg.dead_band) - 1 + int'($urandom_range(0, 2));
                if (off < 0)
                    off = 0;
                return $urandom_range(0, 1) ? 12'(STICK_CENTER + off)
                                            : 12'(STICK_CENTER - off);
            end
            default: return 12'($urandom_range(1000, 2000));
        endcase
    endfunction

    // Step the flight clock; now and then jump to the wrap point or to zero
    function automatic logic [31:0] next_now();
        case ($urandom_range(0, 63))
            0: flight_ms = 32'hFFFF_FFFF -
                           $urandom_range(0, 3 * int'(mapper_cfg.hold_time) + 600);
            1: flight_ms = 32'd0;
            default: flight_ms = flight_ms +
                                 $urandom_range(0, int'(mapper_cfg.hold_time) / 2 + 20);
        endcase
        return flight_ms;
    endfunction

    // Offer one frame after a random gap; hold valid until it is taken
    task automatic send_frame(input t_frame f);
        int gap;
        gap = idle_on ? $urandom_range(0, 11) : 0;
        if (gap != 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tdata  = {f.now, f.yaw, f.thr, f.pitch, f.roll};
        i_s_tuser  = f.lost;
        i_s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        setpoint_q.push_back(predict_setpoint(f));
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every pending setpoint has come out
    task automatic drain_setpoints();
        i_s_tvalid = 1'b0;
        while (setpoint_q.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_DEAD_BAND:        mapper_cfg.dead_band        = value[7:0];
            CFG_ARM_THROTTLE_MAX: mapper_cfg.arm_throttle_max = value[11:0];
            CFG_YAW_LOW:          mapper_cfg.yaw_low          = value[11:0];
            CFG_YAW_HIGH:         mapper_cfg.yaw_high         = value[11:0];
            CFG_HOLD_TIME:        mapper_cfg.hold_time        = value;
            CFG_SETTLE_TIME:      mapper_cfg.settle_time      = value;
            CFG_MAX_TILT:         mapper_cfg.max_tilt         = value[6:0];
            CFG_MAX_YAW_RATE:     mapper_cfg.max_yaw_rate     = value[10:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic apply_config(input t_cfg c);
        write_reg(CFG_DEAD_BAND,        {8'd0, c.dead_band});
        write_reg(CFG_ARM_THROTTLE_MAX, {4'd0, c.arm_throttle_max});
        write_reg(CFG_YAW_LOW,          {4'd0, c.yaw_low});
        write_reg(CFG_YAW_HIGH,         {4'd0, c.yaw_high});
        write_reg(CFG_HOLD_TIME,        c.hold_time);
        write_reg(CFG_SETTLE_TIME,      c.settle_time);
        write_reg(CFG_MAX_TILT,         {9'd0, c.max_tilt});
        write_reg(CFG_MAX_YAW_RATE,     {5'd0, c.max_yaw_rate});
    endtask

    // Short runs of arm holds, disarm holds, cruising, link-loss bursts and noise
    task automatic fly_random(input int count);
        int     sent, kind, len;
        t_frame f;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(0, 9);
            len  = $urandom_range(1, 10);
            for (int k = 0; k < len && sent < count; k++) begin
                f = make_frame(stick_pulse(), stick_pulse(), $urandom_range(900, 2100),
                               stick_pulse(), 1'b0, next_now());
                case (kind)
                    0, 1, 2: begin
                        f.thr = 12'($urandom_range(0, mapper_cfg.arm_throttle_max));
                        f.yaw = 12'($urandom_range(mapper_cfg.yaw_high, 4095));
                    end
                    3, 4: begin
                        f.thr = 12'($urandom_range(0, mapper_cfg.arm_throttle_max));
                        f.yaw = 12'($urandom_range(0, mapper_cfg.yaw_low));
                    end
                    7: f.lost = 1'b1;
                    8: f = make_frame($urandom_range(0, 4095), $urandom_range(0, 4095),
                                      $urandom_range(0, 4095), $urandom_range(0, 4095),
                                      1'($urandom_range(0, 1)), $urandom());
                    9: f.lost = (k == 0);
                    default: ;
                endcase
                send_frame(f);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Full deflection both ways, deadband edges and throttle clamps (reset registers)
    task automatic test_stick_extremes();
        send_frame(make_frame(0, 4095, 0, 1500, 1'b0, 32'd10));
        send_frame(make_frame(4095, 0, 4095, 0, 1'b0, 32'd20));
        send_frame(make_frame(1510, 1490, 999, 1511, 1'b0, 32'd30));
        send_frame(make_frame(1489, 1511, 1000, 1489, 1'b0, 32'd40));
        send_frame(make_frame(1000, 2000, 2001, 1999, 1'b0, 32'd50));
    endtask

    // Gesture starting at time zero only begins timing on the next frame;
    // arm exactly at hold_time, check the settle window edge, then disarm
    task automatic test_arm_hold();
        send_frame(make_frame(1500, 1500, 1000, 1900, 1'b0, 32'd0));
        send_frame(make_frame(1500, 1500, 1000, 1900, 1'b0, 32'd500));
        send_frame(make_frame(1500, 1500, 1000, 1900, 1'b0, 32'd1499));
        send_frame(make_frame(2000, 1000, 1000, 1900, 1'b0, 32'd1500));
        send_frame(make_frame(2000, 1000, 1500, 4095, 1'b0, 32'd1999));
        send_frame(make_frame(2000, 1000, 1500, 4095, 1'b0, 32'd2000));
        send_frame(make_frame(1700, 1300, 1100, 1100, 1'b0, 32'd3000));
        send_frame(make_frame(1700, 1300, 1100, 1100, 1'b0, 32'd4000));
    endtask

    // Arm so late that the settle window wraps and ends at once; disarm across the wrap
    task automatic test_time_wrap();
        send_frame(make_frame(1800, 1200, 500, 4095, 1'b0, 32'hFFFF_F000));
        send_frame(make_frame(1800, 1200, 500, 4095, 1'b0, 32'hFFFF_FF80));
        send_frame(make_frame(1200, 1800, 0, 0, 1'b0, 32'hFFFF_FF90));
        send_frame(make_frame(1200, 1800, 0, 0, 1'b0, 32'h0000_0400));
    endtask

    // Short loss keeps the craft armed, four in a row disarm, the streak saturates
    task automatic test_link_loss();
        logic [31:0] t;
        t = 32'h0001_0000;
        send_frame(make_frame(1500, 1500, 1000, 2000, 1'b0, t));
        send_frame(make_frame(1500, 1500, 1000, 2000, 1'b0, t + 32'd1024));
        for (int k = 1; k <= 8; k++)
            send_frame(make_frame(1700, 1300, 1500, 1600, 1'b1, t + 32'd1024 + 32'(10 * k)));
        send_frame(make_frame(1700, 1300, 1500, 1600, 1'b0, t + 32'd2000));
    endtask

    // Hold the output off for a long stretch while frames keep coming back to back
    task automatic test_output_backpressure();
        idle_on  = 1'b0;
        hold_out = 1'b1;
        for (int k = 0; k < 12; k++)
            send_frame(make_frame(stick_pulse(), stick_pulse(), $urandom_range(0, 4095),
                                  stick_pulse(), 1'b0, next_now()));
        idle_on = 1'b1;
        drain_setpoints();
    endtask

    // A stretch with neither side idling
    task automatic test_back_to_back(input int count);
        idle_on = 1'b0;
        fly_random(count);
        idle_on = 1'b1;
    endtask

    // Quiesce, load a register set, then fly random sequences under it
    task automatic test_flight_phase(input t_cfg c, input int count);
        drain_setpoints();
        apply_config(c);
        fly_random(count);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall per result, one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int stall;
        i_m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_out) begin
                i_m_tready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_out = 1'b0;
            end
            stall = idle_on ? $urandom_range(0, 11) : 0;
            if (stall != 0) begin
                i_m_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    // ------------------------------------------------------------------
    // Result check against the oldest pending setpoint
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_setpoint want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (setpoint_q.size() == 0) begin
                $error("setpoint item with none pending: tdata 0x%0h tuser 0x%0h",
                       o_m_tdata, o_m_tuser);
                error_count++;
            end else begin
                want = setpoint_q.pop_front();
                check_field("roll_angle",   want.roll,               o_m_tdata[15:0]);
                check_field("pitch_angle",  want.pitch,              o_m_tdata[31:16]);
                check_field("yaw_rate",     want.yaw,                o_m_tdata[47:32]);
                check_field("throttle_out", {4'd0, want.thr},        {4'd0, o_m_tdata[59:48]});
                check_field("tdata_pad",    16'd0,                   {12'd0, o_m_tdata[63:60]});
                check_field("armed_now",    {15'd0, want.armed},     {15'd0, o_m_tuser[0]});
                check_field("arm_edge",     {15'd0, want.arm_edge},  {15'd0, o_m_tuser[1]});
                check_field("disarm_edge",  {15'd0, want.disarm_edge}, {15'd0, o_m_tuser[2]});
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_cfg low_edge, high_edge, mid_cfg, wide_cfg;

        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_DEAD_BAND;
        i_cfg_data  = '0;

        mapper_cfg      = CFG_RESET;
        craft_armed     = 1'b0;
        gesture_t0      = '0;
        loss_run        = '0;
        settle_deadline = '0;
        flight_ms       = 32'd100;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_stick_extremes();
        test_arm_hold();
        test_time_wrap();
        test_link_loss();
        test_output_backpressure();
        fly_random(400);
        test_back_to_back(150);

        // Zero deadband and hold/settle, gestures on any throttle, largest scales
        low_edge = '{dead_band: 8'd0, arm_throttle_max: 12'd4095, yaw_low: 12'd0,
                     yaw_high: 12'd4095, hold_time: 16'd0, settle_time: 16'd0,
                     max_tilt: 7'd127, max_yaw_rate: 11'd2047};
        test_flight_phase(low_edge, 350);

        // Widest deadband, longest windows, zero scales, overlapping yaw thresholds
        high_edge = '{dead_band: 8'd255, arm_throttle_max: 12'd0, yaw_low: 12'd4095,
                      yaw_high: 12'd0, hold_time: 16'hFFFF, settle_time: 16'hFFFF,
                      max_tilt: 7'd0, max_yaw_rate: 11'd0};
        test_flight_phase(high_edge, 350);

        mid_cfg = '{dead_band: 8'($urandom_range(0, 250)),
                    arm_throttle_max: 12'($urandom_range(900, 1300)),
                    yaw_low: 12'($urandom_range(900, 1300)),
                    yaw_high: 12'($urandom_range(1700, 2100)),
                    hold_time: 16'($urandom_range(0, 3000)),
                    settle_time: 16'($urandom_range(0, 2000)),
                    max_tilt: 7'($urandom_range(0, 90)),
                    max_yaw_rate: 11'($urandom_range(0, 2000))};
        test_flight_phase(mid_cfg, 350);

        wide_cfg = '{dead_band: 8'd250, arm_throttle_max: 12'd1100, yaw_low: 12'd1100,
                     yaw_high: 12'd1900, hold_time: 16'd50, settle_time: 16'd20,
                     max_tilt: 7'd90, max_yaw_rate: 11'd2000};
        test_flight_phase(wide_cfg, 350);

        // Let the last setpoints out, then give the pipeline time to show strays
        drain_setpoints();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("rc_stick_arming_setpoint_mapper_test: PASS");
        end else begin
            $display("rc_stick_arming_setpoint_mapper_test: FAIL");
        end
        $finish;
    end

    // Watchdog for a hung handshake
    initial begin
        #(TIMEOUT_NS);
        $display("rc_stick_arming_setpoint_mapper_test: FAIL");
        $finish;
    end

endmodule

// ===== rc_stick_arming_setpoint_mapper.f =====
rtl/rcsam_pkg.sv
rtl/rcsam_lane.sv
rtl/rcsam_arm.sv
rtl/rc_stick_arming_setpoint_mapper.sv
rtl/rcsam_chk.sv
tb/rc_stick_arming_setpoint_mapper_test.sv
